FILE: rtl/core/assert_macros.svh
// ---------------------------------------------------------------------------
// assert_macros.svh
// Assertion shorthands, clocked on i_clk with reset held off.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check that prop holds at every clock edge outside reset.
`define ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) \
        else $error(msg);

// Check that cons holds in the cycle after ante.
`define ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |=> (cons)) else $error(msg);

`endif

FILE: rtl/core/sse_pkg.sv
// ---------------------------------------------------------------------------
// sse_pkg
// Sizes, types and sequencer status shared by the sort engine files.
// ---------------------------------------------------------------------------
package sse_pkg;

    localparam int DEPTH      = 64;
    localparam int DATA_WIDTH = 16;
    localparam int ADDR_W     = $clog2(DEPTH);
    localparam int CNT_W      = $clog2(DEPTH + 1);
    localparam int GAP_W      = $clog2(DEPTH / 2 + 1);

    typedef logic [DATA_WIDTH-1:0] t_data;
    typedef logic [ADDR_W-1:0]     t_addr;
    typedef logic [CNT_W-1:0]      t_cnt;
    typedef logic [GAP_W-1:0]      t_gap;

    typedef struct packed {
        logic load;
        logic fin;
    } t_emit;

    typedef struct packed {
        logic busy;
        t_cnt cnt;
    } t_stat;

endpackage

FILE: rtl/core/sse_ram.sv
// ---------------------------------------------------------------------------
// sse_ram
// Element store: one write port, two read ports, registered read data.
// ---------------------------------------------------------------------------
module sse_ram #(
    parameter int DEPTH_P = 64,
    parameter int WIDTH_P = 16,
    parameter int AW_P    = $clog2(DEPTH_P)
) (
    input  logic               i_clk,
    input  logic               i_we,
    input  logic [AW_P-1:0]    i_waddr,
    input  logic [WIDTH_P-1:0] i_wdata,
    input  logic [AW_P-1:0]    i_raddr_a,
    input  logic [AW_P-1:0]    i_raddr_b,
    output logic [WIDTH_P-1:0] o_rdata_a,
    output logic [WIDTH_P-1:0] o_rdata_b
);

    logic [WIDTH_P-1:0] r_mem [DEPTH_P];
    logic [WIDTH_P-1:0] r_rdata_a;
    logic [WIDTH_P-1:0] r_rdata_b;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata_a <= r_mem[i_raddr_a];
        r_rdata_b <= r_mem[i_raddr_b];
    end

    assign o_rdata_a = r_rdata_a;
    assign o_rdata_b = r_rdata_b;

endmodule

FILE: rtl/core/sse_seq.sv
// ---------------------------------------------------------------------------
// sse_seq
// Load, gapped insertion and emit sequencer around the element store.
// ---------------------------------------------------------------------------
module sse_seq (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    output logic             o_in_stall,
    input  sse_pkg::t_data   i_value,
    input  logic             i_last,
    input  sse_pkg::t_data   i_rd_a,
    input  sse_pkg::t_data   i_rd_b,
    input  logic             i_out_free,
    output logic             o_we,
    output sse_pkg::t_addr   o_waddr,
    output sse_pkg::t_data   o_wdata,
    output sse_pkg::t_addr   o_raddr_a,
    output sse_pkg::t_addr   o_raddr_b,
    output sse_pkg::t_emit   o_emit,
    output sse_pkg::t_stat   o_stat
);

    localparam logic [2:0] S_LOAD    = 3'd0;
    localparam logic [2:0] S_OUTER   = 3'd1;
    localparam logic [2:0] S_RD      = 3'd2;
    localparam logic [2:0] S_CMP     = 3'd3;
    localparam logic [2:0] S_SWP     = 3'd4;
    localparam logic [2:0] S_EMIT_RD = 3'd5;
    localparam logic [2:0] S_EMIT_LD = 3'd6;

    logic [2:0]      r_state, n_state;
    sse_pkg::t_cnt   r_cnt, n_cnt;
    sse_pkg::t_gap   r_gap, n_gap;
    sse_pkg::t_cnt   r_outer, n_outer;
    sse_pkg::t_cnt   r_inner, n_inner;
    sse_pkg::t_addr  r_k, n_k;
    sse_pkg::t_data  r_small, n_small;

    sse_pkg::t_cnt   w_gap_ext;
    sse_pkg::t_cnt   w_jb;
    sse_pkg::t_cnt   w_cnt_after;
    sse_pkg::t_cnt   w_half;
    sse_pkg::t_gap   w_gap_half;
    logic            w_accept;

    assign w_gap_ext   = sse_pkg::t_cnt'(r_gap);
    assign w_jb        = r_inner - w_gap_ext;
    assign w_accept    = i_in_valid && (r_state == S_LOAD);
    assign w_cnt_after = (r_cnt < sse_pkg::t_cnt'(sse_pkg::DEPTH)) ? r_cnt + 1'b1 : r_cnt;
    assign w_half      = w_cnt_after >> 1;
    assign w_gap_half  = r_gap >> 1;

    always_comb begin
        n_state   = r_state;
        n_cnt     = r_cnt;
        n_gap     = r_gap;
        n_outer   = r_outer;
        n_inner   = r_inner;
        n_k       = r_k;
        n_small   = r_small;
        o_we      = 1'b0;
        o_waddr   = r_cnt[sse_pkg::ADDR_W-1:0];
        o_wdata   = i_value;
        o_raddr_a = r_inner[sse_pkg::ADDR_W-1:0];
        o_raddr_b = w_jb[sse_pkg::ADDR_W-1:0];
        o_emit    = '0;

        unique case (r_state)
            S_LOAD: begin
                if (w_accept) begin
                    o_we  = (r_cnt < sse_pkg::t_cnt'(sse_pkg::DEPTH));
                    n_cnt = w_cnt_after;
                    if (i_last) begin
                        n_gap   = w_half[sse_pkg::GAP_W-1:0];
                        n_outer = w_half;
                        n_k     = '0;
                        n_state = (w_half == '0) ? S_EMIT_RD : S_OUTER;
                    end
                end
            end
            S_OUTER: begin
                if (r_outer >= r_cnt) begin
                    n_gap   = w_gap_half;
                    n_outer = sse_pkg::t_cnt'(w_gap_half);
                    n_k     = '0;
                    n_state = (w_gap_half == '0) ? S_EMIT_RD : S_OUTER;
                end else begin
                    n_inner = r_outer;
                    n_state = S_RD;
                end
            end
            S_RD: begin
                if (r_inner < w_gap_ext) begin
                    n_outer = r_outer + 1'b1;
                    n_state = S_OUTER;
                end else begin
                    n_state = S_CMP;
                end
            end
            S_CMP: begin
                if (i_rd_a < i_rd_b) begin
                    o_we    = 1'b1;
                    o_waddr = r_inner[sse_pkg::ADDR_W-1:0];
                    o_wdata = i_rd_b;
                    n_small = i_rd_a;
                    n_state = S_SWP;
                end else begin
                    n_outer = r_outer + 1'b1;
                    n_state = S_OUTER;
                end
            end
            S_SWP: begin
                o_we    = 1'b1;
                o_waddr = w_jb[sse_pkg::ADDR_W-1:0];
                o_wdata = r_small;
                n_inner = w_jb;
                n_state = S_RD;
            end
            S_EMIT_RD: begin
                o_raddr_a = r_k;
                n_state   = S_EMIT_LD;
            end
            S_EMIT_LD: begin
                o_raddr_a = r_k;
                if (i_out_free) begin
                    o_emit.load = 1'b1;
                    o_emit.fin  = (sse_pkg::t_cnt'(r_k) + 1'b1 == r_cnt);
                    if (o_emit.fin) begin
                        n_cnt   = '0;
                        n_gap   = '0;
                        n_outer = '0;
                        n_inner = '0;
                        n_state = S_LOAD;
                    end else begin
                        n_k     = r_k + 1'b1;
                        n_state = S_EMIT_RD;
                    end
                end
            end
            default: begin
                n_state = S_LOAD;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_LOAD;
            r_cnt   <= '0;
            r_gap   <= '0;
            r_outer <= '0;
            r_inner <= '0;
            r_k     <= '0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
            r_gap   <= n_gap;
            r_outer <= n_outer;
            r_inner <= n_inner;
            r_k     <= n_k;
        end
        r_small <= n_small;
    end

    assign o_in_stall  = (r_state != S_LOAD);
    assign o_stat.busy = (r_state != S_LOAD);
    assign o_stat.cnt  = r_cnt;

endmodule

FILE: rtl/core/shell_sort_engine.sv
// ---------------------------------------------------------------------------
// shell_sort_engine
// Collects a set of words, sorts them ascending by Shell sort with halving
// gaps, then streams them out with a final flag on the last one.
// ---------------------------------------------------------------------------
// channel | valid       | stall        | payload
// input   | i_in_valid  | o_in_stall   | i_value, i_last
// output  | o_out_valid | i_out_stall  | o_sorted_value, o_final_res
//
// Loading takes one word per cycle while o_in_stall is low; words past 64
// are dropped. Sorting runs in the element store: each compare uses a read
// state and a compare state, a swap adds a swap state, and an outer step its
// own state. Emission reads, then loads each word, waiting on output stall.
// Input stalls from the last word until the last result enters the output
// register. Reset is synchronous; the store itself is not cleared.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module shell_sort_engine (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    output logic           o_in_stall,
    input  sse_pkg::t_data i_value,
    input  logic           i_last,
    output logic           o_out_valid,
    input  logic           i_out_stall,
    output sse_pkg::t_data o_sorted_value,
    output logic           o_final_res
);

    logic            w_we;
    sse_pkg::t_addr  w_waddr;
    sse_pkg::t_data  w_wdata;
    sse_pkg::t_addr  w_raddr_a;
    sse_pkg::t_addr  w_raddr_b;
    sse_pkg::t_data  w_rd_a;
    sse_pkg::t_data  w_rd_b;
    sse_pkg::t_emit  w_emit;
    sse_pkg::t_stat  w_stat;
    logic            w_out_free;

    logic            r_out_valid;
    sse_pkg::t_data  r_out_value;
    logic            r_out_final;

    assign w_out_free = !r_out_valid || !i_out_stall;

    sse_ram #(
        .DEPTH_P (sse_pkg::DEPTH),
        .WIDTH_P (sse_pkg::DATA_WIDTH)
    ) u_ram (
        .i_clk     (i_clk),
        .i_we      (w_we),
        .i_waddr   (w_waddr),
        .i_wdata   (w_wdata),
        .i_raddr_a (w_raddr_a),
        .i_raddr_b (w_raddr_b),
        .o_rdata_a (w_rd_a),
        .o_rdata_b (w_rd_b)
    );

    sse_seq u_seq (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_value    (i_value),
        .i_last     (i_last),
        .i_rd_a     (w_rd_a),
        .i_rd_b     (w_rd_b),
        .i_out_free (w_out_free),
        .o_we       (w_we),
        .o_waddr    (w_waddr),
        .o_wdata    (w_wdata),
        .o_raddr_a  (w_raddr_a),
        .o_raddr_b  (w_raddr_b),
        .o_emit     (w_emit),
        .o_stat     (w_stat)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_emit.load) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
        if (w_emit.load) begin
            r_out_value <= w_rd_a;
            r_out_final <= w_emit.fin;
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_sorted_value = r_out_value;
    assign o_final_res    = r_out_final;

    `ASSERT_ALWAYS(a_cnt_bound, w_stat.cnt <= sse_pkg::t_cnt'(sse_pkg::DEPTH), "count past depth")
    `ASSERT_ALWAYS(a_no_overwrite, !w_emit.load || w_out_free, "output word overwritten")
    `ASSERT_NEXT(a_fin_idle, w_emit.load && w_emit.fin, !w_stat.busy && (w_stat.cnt == '0), "not idle after final word")
    `ASSERT_ALWAYS(a_no_write_emit, !(w_emit.load && w_we), "store written during emit")

endmodule
